>>> src/min_heap_priority_queue_macros.svh
// Assertion macros for the priority queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// Next-cycle implication, checked out of reset.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

>>> src/mhpq_pkg.sv
// Types and constants of the priority queue.
package mhpq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_t;

  typedef enum logic {
    KindInsert = 1'b0,
    KindRemove = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  localparam value_t EmptyMark = -32'sd99999;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic   ins;
    logic   rem;
    value_t x;
  } cell_op_t;

  // What a cell hands to its neighbors.
  typedef struct packed {
    value_t value;
    logic   valid;
  } link_t;

endpackage

>>> src/mhpq_cell.sv
// One cell of the sorted chain: holds one value and shifts with its neighbors.
module mhpq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mhpq_pkg::cell_op_t op_i,
  input  mhpq_pkg::link_t  left_i,
  input  logic             left_gt_i,
  input  mhpq_pkg::link_t  right_i,
  output mhpq_pkg::link_t  own_o,
  output logic             gt_o
);
  import mhpq_pkg::*;

  value_t value_q, value_d;
  logic   valid_q, valid_d;

  // An empty cell counts as holding plus infinity, so the flags run
  // false up to the insert point and true from there on.
  assign gt_o = !valid_q || (op_i.x < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (op_i.ins) begin
      if (gt_o) begin
        if (left_gt_i) begin
          value_d = left_i.value;
          valid_d = left_i.valid;
        end else begin
          value_d = op_i.x;
          valid_d = 1'b1;
        end
      end
    end else if (op_i.rem) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign own_o.value = value_q;
  assign own_o.valid = valid_q;

endmodule

>>> src/min_heap_priority_queue.sv
// Min priority queue built as a sorted chain of cells with a registered output.
//
//   channel   dir  payload
//   s_axis    in   tuser = kind, tdata = value
//   m_axis    out  tuser = status, tdata = removed_value, count
//   cfg       in   cfg_wdata_i = capacity (write on cfg_we_i)
//
// All cells compare against an item and shift in the cycle it is accepted,
// and its result sits in the output register from the next one.
// A new item is taken whenever the output register is empty or being drained.
// Reset empties the chain (cell valid bits) and sets capacity to 64.
// A stall on m_axis holds the result and stops intake; nothing is lost.
module min_heap_priority_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // [31:0] value
  input  logic                       s_axis_tuser,  // [0] kind
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // [31:0] removed_value, [38:32] count
  output logic [1:0]                 m_axis_tuser,  // [1:0] status
  input  logic                       cfg_we_i,
  input  logic [mhpq_pkg::CountW-1:0] cfg_wdata_i
);
  import mhpq_pkg::*;

  `include "min_heap_priority_queue_macros.svh"

  localparam int unsigned CountMax = (1 << CountW) - 1;
  localparam count_t DepthSat = count_t'((DEPTH > CountMax) ? CountMax : DEPTH);

  count_t   capacity_q;
  count_t   count_q, count_d;
  count_t   limit;
  logic     out_valid_q;
  value_t   out_removed_q, out_removed_d;
  status_e  out_status_q, out_status_d;
  count_t   out_count_q;
  logic     fire;
  kind_e    kind;
  cell_op_t op;

  link_t    cells   [DEPTH];
  logic     cell_gt [DEPTH];

  assign kind          = kind_e'(s_axis_tuser);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign limit         = (capacity_q > DepthSat) ? DepthSat : capacity_q;

  always_comb begin
    op.ins        = 1'b0;
    op.rem        = 1'b0;
    op.x          = s_axis_tdata;
    count_d       = count_q;
    out_removed_d = '0;
    out_status_d  = StDone;
    unique case (kind)
      KindInsert: begin
        if (count_q >= limit) begin
          out_status_d = StFull;
        end else begin
          op.ins  = fire;
          count_d = count_q + count_t'(1);
        end
      end
      KindRemove: begin
        if (count_q == '0) begin
          out_removed_d = EmptyMark;
          out_status_d  = StEmpty;
        end else begin
          op.rem        = fire;
          out_removed_d = cells[0].value;
          count_d       = count_q - count_t'(1);
        end
      end
      default: begin
        out_status_d = StDone;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left_link, right_link;
    logic  left_gt;
    if (i == 0) begin : g_head
      assign left_link = '{value: '0, valid: 1'b1};
      assign left_gt   = 1'b0;
    end else begin : g_body
      assign left_link = cells[i-1];
      assign left_gt   = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_link = '{value: '0, valid: 1'b0};
    end else begin : g_next
      assign right_link = cells[i+1];
    end
    mhpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .left_i    (left_link),
      .left_gt_i (left_gt),
      .right_i   (right_link),
      .own_o     (cells[i]),
      .gt_o      (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= count_t'(64);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_removed_q <= out_removed_d;
      out_status_q  <= out_status_d;
      out_count_q   <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_removed_q};
  assign m_axis_tuser  = out_status_q;

  `MHPQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= DepthSat)
  `MHPQ_ASSERT_NOW(a_head_valid, clk_i, rst_ni, 1'b1, cells[0].valid == (count_q != '0))
  `MHPQ_ASSERT_NEXT(a_empty_status, clk_i, rst_ni,
    fire && kind == KindRemove && count_q == '0, out_status_q == StEmpty)

endmodule

>>> bench/testbench.sv
// Self-checking bench for the min-heap priority queue with random stream traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned ShowLimit  = 10;

  typedef struct packed {
    kind_e  kind;
    value_t value;
  } queue_op_t;

  typedef struct packed {
    value_t  removed;
    status_e status;
    count_t  count;
  } queue_reply_t;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         s_axis_tvalid  = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata   = '0;
  logic         s_axis_tuser   = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready  = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i       = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;

  queue_op_t    pending_ops[$];
  queue_reply_t expected_replies[$];
  value_t       heap_vals[Depth];
  int unsigned  heap_count = 0;
  count_t       cap_reg = count_t'(64);
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;
  bit           calm = 1'b0;
  bit           sender_hold = 1'b0;
  bit           in_taken = 1'b0;
  queue_reply_t want;
  queue_reply_t got;

  min_heap_priority_queue #(.DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void heap_swap(int unsigned a, int unsigned b);
    value_t t;
    t = heap_vals[a];
    heap_vals[a] = heap_vals[b];
    heap_vals[b] = t;
  endfunction

  // Applies one operation to the shadow heap and returns the reply it should produce.
  function automatic queue_reply_t heap_apply(queue_op_t op);
    int unsigned limit, pos, parent, left, right, best;
    bit done;
    queue_reply_t r;
    r.removed = '0;
    r.status = StDone;
    limit = (cap_reg > Depth) ? Depth : cap_reg;
    done = 1'b0;
    if (op.kind == KindInsert) begin
      if (heap_count >= limit) begin
        r.status = StFull;
      end else begin
        pos = heap_count;
        heap_vals[pos] = op.value;
        heap_count++;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_vals[pos] < heap_vals[parent]) begin
            heap_swap(pos, parent);
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else if (heap_count == 0) begin
      r.removed = EmptyMark;
      r.status = StEmpty;
    end else begin
      r.removed = heap_vals[0];
      heap_count--;
      heap_vals[0] = heap_vals[heap_count];
      pos = 0;
      while (!done) begin
        left = 2 * pos + 1;
        right = left + 1;
        best = pos;
        if (left < heap_count && heap_vals[left] < heap_vals[best]) best = left;
        if (right < heap_count && heap_vals[right] < heap_vals[best]) best = right;
        if (best == pos) begin
          done = 1'b1;
        end else begin
          heap_swap(pos, best);
          pos = best;
        end
      end
    end
    r.count = count_t'(heap_count);
    return r;
  endfunction

  // Input words are predicted the moment they are accepted.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_replies.push_back(heap_apply(pending_ops.pop_front()));
      in_taken = 1'b1;
    end
  end

  // A presented word stays put until taken; idling is decided only between words.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pending_ops.size() != 0 && !sender_hold && (calm || $urandom_range(0, 99) >= 25)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_ops[0].value;
        s_axis_tuser  <= pending_ops[0].kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got.removed = m_axis_tdata[31:0];
      got.count   = m_axis_tdata[38:32];
      got.status  = status_e'(m_axis_tuser);
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected word: removed %0d status %0d count %0d",
                   got.removed, got.status, got.count);
      end else begin
        want = expected_replies.pop_front();
        if (got.removed != want.removed || got.status != want.status ||
            got.count != want.count) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display("mismatch: expected removed %0d status %0d count %0d, got %0d %0d %0d",
                     want.removed, want.status, want.count,
                     got.removed, got.status, got.count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_op(kind_e kind, value_t value);
    queue_op_t op;
    op.kind = kind;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_replies.size() != 0) @(negedge clk_i);
  endtask

  // Only called with the queue idle, so no word sees a half-applied capacity.
  task automatic write_capacity(count_t cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = cap;
  endtask

  function automatic value_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return value_t'(32'h8000_0000);
    if (sel == 1) return value_t'(32'h7fff_ffff);
    // A narrow band gives plenty of equal values.
    if (sel < 5) return value_t'($signed($urandom_range(0, 16)) - 8);
    return value_t'($urandom);
  endfunction

  task automatic run_phase(count_t cap, int unsigned n, int unsigned insert_pct,
                           bit quiet, bit pause_mid);
    drain();
    write_capacity(cap);
    calm = quiet;
    for (int unsigned i = 0; i < n; i++)
      push_op(($urandom_range(0, 99) < insert_pct) ? KindInsert : KindRemove, pick_value());
    if (pause_mid) begin
      while (pending_ops.size() > n / 2) @(negedge clk_i);
      sender_hold = 1'b1;
      while (expected_replies.size() != 0) @(negedge clk_i);
      repeat (3) @(negedge clk_i);
      sender_hold = 1'b0;
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty remove, extremes, the empty marker as data, and ties.
    push_op(KindRemove, '0);
    push_op(KindInsert, value_t'(32'h7fff_ffff));
    push_op(KindInsert, value_t'(32'h8000_0000));
    push_op(KindInsert, '0);
    push_op(KindInsert, value_t'(-1));
    push_op(KindInsert, EmptyMark);
    for (int i = 0; i < 3; i++) push_op(KindInsert, value_t'(5));
    for (int i = 0; i < 9; i++) push_op(KindRemove, value_t'($urandom));
    drain();

    // Tiny capacity: one insert is turned away.
    write_capacity(count_t'(2));
    push_op(KindInsert, value_t'(7));
    push_op(KindInsert, value_t'(3));
    push_op(KindInsert, value_t'(9));
    for (int i = 0; i < 3; i++) push_op(KindRemove, '0);

    run_phase(count_t'(127), 200, 80, 1'b0, 1'b0);
    run_phase(count_t'(5), 120, 45, 1'b0, 1'b0);
    run_phase(count_t'(0), 40, 60, 1'b0, 1'b0);
    run_phase(count_t'(1), 80, 50, 1'b0, 1'b0);
    run_phase(count_t'(64), 250, 55, 1'b1, 1'b0);
    run_phase(count_t'($urandom_range(2, 63)), 200, 50, 1'b0, 1'b1);
    run_phase(count_t'(64), 150, 30, 1'b0, 1'b0);
    run_phase(count_t'($urandom_range(0, 127)), 110, 50, 1'b0, 1'b0);

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
